>>> sv/rebd_pkg.sv
// Package: shared types, register map and result codes of the rotary encoder decoder
package rebd_pkg;

   localparam int CNT_W = 14;

   localparam logic [CNT_W-1:0] PRESS_COUNT_LIMIT = 14'd10000;
   localparam logic [CNT_W-1:0] CNT_MAX           = 14'h3fff;

   localparam int PADDR_W = 5;
   localparam int PDATA_W = 32;

   localparam logic [2:0] REG_ENCODER_TYPE  = 3'd0;
   localparam logic [2:0] REG_DEBOUNCE      = 3'd1;
   localparam logic [2:0] REG_LONG_PRESS    = 3'd2;
   localparam logic [2:0] REG_DOUBLE_CLICK  = 3'd3;
   localparam logic [2:0] REG_REPEAT        = 3'd4;

   localparam logic [CNT_W-1:0] DEBOUNCE_RST     = 14'd10;
   localparam logic [CNT_W-1:0] LONG_PRESS_RST   = 14'd250;
   localparam logic [CNT_W-1:0] DOUBLE_CLICK_RST = 14'd150;
   localparam logic [CNT_W-1:0] REPEAT_RST       = 14'd100;

   localparam logic signed [2:0] SCAN_NONE    = 3'sd0;
   localparam logic signed [2:0] SCAN_FWD     = 3'sd1;
   localparam logic signed [2:0] SCAN_REV     = -3'sd1;
   localparam logic signed [2:0] SCAN_KEY     = 3'sd2;
   localparam logic signed [2:0] SCAN_KEY_FWD = 3'sd3;
   localparam logic signed [2:0] SCAN_KEY_REV = -3'sd3;

   localparam logic [2:0] ACT_NONE     = 3'd0;
   localparam logic [2:0] ACT_SHORT    = 3'd1;
   localparam logic [2:0] ACT_DOUBLE   = 3'd2;
   localparam logic [2:0] ACT_LONG_END = 3'd3;
   localparam logic [2:0] ACT_REPEAT   = 3'd4;

   localparam logic [2:0] EVT_NONE     = 3'd0;
   localparam logic [2:0] EVT_INC      = 3'd1;
   localparam logic [2:0] EVT_DEC      = 3'd2;
   localparam logic [2:0] EVT_HELD_INC = 3'd3;
   localparam logic [2:0] EVT_HELD_DEC = 3'd4;
   localparam logic [2:0] EVT_SHORT    = 3'd5;
   localparam logic [2:0] EVT_DOUBLE   = 3'd6;

   typedef struct packed {
      logic             encoder_type;
      logic [CNT_W-1:0] debounce_ticks;
      logic [CNT_W-1:0] long_press_ticks;
      logic [CNT_W-1:0] double_click_ticks;
      logic [CNT_W-1:0] repeat_ticks;
   } cfg_type;

   typedef struct packed {
      logic a_level;
      logic b_level;
      logic key_level;
   } sample_type;

   typedef struct packed {
      logic signed [2:0] scan_code;
      logic [2:0]        action_code;
      logic [2:0]        event_code;
   } result_type;

endpackage

>>> sv/rebd_chan_if.sv
// Interfaces: sample beat channel and result beat channel
interface rebd_req_if;
   logic valid;
   logic ready;
   logic a_level;
   logic b_level;
   logic key_level;

   modport source (output valid, output a_level, output b_level, output key_level,
                   input ready);
   modport sink   (input valid, input a_level, input b_level, input key_level,
                   output ready);
endinterface

interface rebd_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [2:0] scan_code;
   logic [2:0]        action_code;
   logic [2:0]        event_code;

   modport source (output valid, output scan_code, output action_code, output event_code,
                   input ready);
   modport sink   (input valid, input scan_code, input action_code, input event_code,
                   output ready);
endinterface

>>> sv/rebd_csr.sv
// Configuration registers behind the APB-style port
module rebd_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [rebd_pkg::PADDR_W-1:0] paddr,
   input  logic [rebd_pkg::PDATA_W-1:0] pwdata,
   output logic [rebd_pkg::PDATA_W-1:0] prdata,
   output logic                         pready,
   output rebd_pkg::cfg_type            cfg
);

   rebd_pkg::cfg_type cfg_ff;
   rebd_pkg::cfg_type cfg_in;
   logic              wr_en;
   logic [2:0]        reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[rebd_pkg::PADDR_W-1:2];
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            rebd_pkg::REG_ENCODER_TYPE: cfg_in.encoder_type = pwdata[0];
            rebd_pkg::REG_DEBOUNCE:
               cfg_in.debounce_ticks = pwdata[rebd_pkg::CNT_W-1:0];
            rebd_pkg::REG_LONG_PRESS:
               cfg_in.long_press_ticks = pwdata[rebd_pkg::CNT_W-1:0];
            rebd_pkg::REG_DOUBLE_CLICK:
               cfg_in.double_click_ticks = pwdata[rebd_pkg::CNT_W-1:0];
            rebd_pkg::REG_REPEAT:
               cfg_in.repeat_ticks = pwdata[rebd_pkg::CNT_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         rebd_pkg::REG_ENCODER_TYPE:
            prdata = {{(rebd_pkg::PDATA_W-1){1'b0}}, cfg_ff.encoder_type};
         rebd_pkg::REG_DEBOUNCE:
            prdata = {{(rebd_pkg::PDATA_W-rebd_pkg::CNT_W){1'b0}}, cfg_ff.debounce_ticks};
         rebd_pkg::REG_LONG_PRESS:
            prdata = {{(rebd_pkg::PDATA_W-rebd_pkg::CNT_W){1'b0}}, cfg_ff.long_press_ticks};
         rebd_pkg::REG_DOUBLE_CLICK:
            prdata = {{(rebd_pkg::PDATA_W-rebd_pkg::CNT_W){1'b0}},
                      cfg_ff.double_click_ticks};
         rebd_pkg::REG_REPEAT:
            prdata = {{(rebd_pkg::PDATA_W-rebd_pkg::CNT_W){1'b0}}, cfg_ff.repeat_ticks};
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.encoder_type       <= 1'b1;
         cfg_ff.debounce_ticks     <= rebd_pkg::DEBOUNCE_RST;
         cfg_ff.long_press_ticks   <= rebd_pkg::LONG_PRESS_RST;
         cfg_ff.double_click_ticks <= rebd_pkg::DOUBLE_CLICK_RST;
         cfg_ff.repeat_ticks       <= rebd_pkg::REPEAT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> sv/rebd_engine.sv
// Decoder state and single-pass update: rotation decode and key press classification
module rebd_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  rebd_pkg::cfg_type      cfg,
   input  rebd_pkg::sample_type   sample,
   output rebd_pkg::result_type   result
);

   localparam int W = rebd_pkg::CNT_W;

   logic         a_prev_ff,   a_prev_in;
   logic [W-1:0] press_ff,    press_in;
   logic [W-1:0] gap_ff,      gap_in;
   logic         short_ff,    short_in;
   logic         long_ff,     long_in;
   logic [1:0]   dstage_ff,   dstage_in;
   logic [W-1:0] rep_ff,      rep_in;

   always_comb begin
      logic         fwd;
      logic         rev;
      logic         key_only;
      logic [W-1:0] p1;
      logic [W-1:0] g1;
      logic         sf1;
      logic         lf1;
      logic [1:0]   ds1;
      logic         c_short;
      logic         c_double;
      logic [W-1:0] rc;

      fwd = 1'b0;
      rev = 1'b0;
      if (sample.a_level != a_prev_ff) begin
         if (!cfg.encoder_type) begin
            fwd = !sample.a_level && !sample.b_level;
            rev = !sample.a_level && sample.b_level;
         end else if (sample.a_level) begin
            fwd = !sample.b_level;
            rev = sample.b_level;
         end else begin
            fwd = sample.b_level;
            rev = !sample.b_level;
         end
      end
      a_prev_in = sample.a_level;

      result.action_code = rebd_pkg::ACT_NONE;
      key_only = 1'b0;
      priority if (!sample.key_level && fwd) begin
         result.scan_code  = rebd_pkg::SCAN_KEY_FWD;
         result.event_code = rebd_pkg::EVT_HELD_DEC;
      end else if (!sample.key_level && rev) begin
         result.scan_code  = rebd_pkg::SCAN_KEY_REV;
         result.event_code = rebd_pkg::EVT_HELD_INC;
      end else if (!sample.key_level) begin
         result.scan_code  = rebd_pkg::SCAN_KEY;
         result.event_code = rebd_pkg::EVT_NONE;
         key_only          = 1'b1;
      end else if (fwd) begin
         result.scan_code  = rebd_pkg::SCAN_FWD;
         result.event_code = rebd_pkg::EVT_INC;
      end else if (rev) begin
         result.scan_code  = rebd_pkg::SCAN_REV;
         result.event_code = rebd_pkg::EVT_DEC;
      end else begin
         result.scan_code  = rebd_pkg::SCAN_NONE;
         result.event_code = rebd_pkg::EVT_NONE;
      end

      p1  = press_ff;
      g1  = gap_ff;
      sf1 = short_ff;
      lf1 = long_ff;
      ds1 = dstage_ff;
      if (key_only) begin
         if (press_ff < rebd_pkg::PRESS_COUNT_LIMIT) p1 = press_ff + 1'b1;
         if (p1 == cfg.debounce_ticks) sf1 = 1'b1;
         if (gap_ff != '0 && gap_ff <= cfg.double_click_ticks) ds1 = 2'd1;
         if (p1 == cfg.long_press_ticks) begin
            lf1 = 1'b1;
            sf1 = 1'b0;
         end
      end else if (press_ff < cfg.debounce_ticks) begin
         p1  = '0;
         sf1 = 1'b0;
         lf1 = 1'b0;
         ds1 = 2'd0;
         g1  = '0;
      end else begin
         if (short_ff) begin
            if (dstage_ff == 2'd0 && gap_ff < rebd_pkg::CNT_MAX) g1 = gap_ff + 1'b1;
            if (dstage_ff == 2'd1 && g1 <= cfg.double_click_ticks) ds1 = 2'd2;
            if (dstage_ff == 2'd0 && g1 > cfg.double_click_ticks) sf1 = 1'b0;
         end
         lf1 = 1'b0;
      end

      rc       = rep_ff;
      c_short  = 1'b0;
      c_double = 1'b0;
      if (p1 > cfg.debounce_ticks) begin
         c_short = !sf1 && g1 > cfg.double_click_ticks && p1 < cfg.long_press_ticks;
         c_double = !c_short && ds1 == 2'd2 && g1 != '0 && g1 <= cfg.double_click_ticks;
         if (c_short) begin
            result.action_code = rebd_pkg::ACT_SHORT;
            result.event_code  = rebd_pkg::EVT_SHORT;
            p1  = '0;
            g1  = '0;
            ds1 = 2'd0;
         end
         if (c_double) begin
            result.action_code = rebd_pkg::ACT_DOUBLE;
            result.event_code  = rebd_pkg::EVT_DOUBLE;
            p1  = '0;
            g1  = '0;
            sf1 = 1'b0;
            ds1 = 2'd0;
         end
         if (lf1 && p1 >= cfg.long_press_ticks) begin
            rc = rep_ff + 1'b1;
            if (rc >= cfg.repeat_ticks) begin
               rc = '0;
               result.action_code = rebd_pkg::ACT_REPEAT;
            end
         end
         if (!lf1 && p1 >= cfg.long_press_ticks) begin
            result.action_code = rebd_pkg::ACT_LONG_END;
            p1 = '0;
         end
      end

      press_in  = p1;
      gap_in    = g1;
      short_in  = sf1;
      long_in   = lf1;
      dstage_in = ds1;
      rep_in    = rc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_prev_ff <= 1'b1;
         press_ff  <= '0;
         gap_ff    <= '0;
         short_ff  <= 1'b0;
         long_ff   <= 1'b0;
         dstage_ff <= 2'd0;
         rep_ff    <= '0;
      end else if (step) begin
         a_prev_ff <= a_prev_in;
         press_ff  <= press_in;
         gap_ff    <= gap_in;
         short_ff  <= short_in;
         long_ff   <= long_in;
         dstage_ff <= dstage_in;
         rep_ff    <= rep_in;
      end
   end

endmodule

>>> sv/rotary_encoder_button_decoder.sv
// Top level: rotary encoder and push key decoder with sample and result registers
//
//   channel   direction  beat payload                          handshake
//   req_bus   in         a_level, b_level, key_level           valid/ready
//   rsp_bus   out        scan_code, action_code, event_code    valid/ready
//   csr       in         APB write/read of five registers      psel/penable, pready=1
//
// One sample beat per cycle while the result side is not stalled.
// The decode and press logic sits between the sample register and the result register.
// Synchronous reset clears both registers' valid flags and the decoder state, and resets the config to defaults.
// A stalled result holds; the sample register still takes a beat, then waits.
module rotary_encoder_button_decoder (
   input  logic                         clock,
   input  logic                         reset,
   rebd_req_if.sink                     req_bus,
   rebd_rsp_if.source                   rsp_bus,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [rebd_pkg::PADDR_W-1:0] paddr,
   input  logic [rebd_pkg::PDATA_W-1:0] pwdata,
   output logic [rebd_pkg::PDATA_W-1:0] prdata,
   output logic                         pready
);

   rebd_pkg::cfg_type    cfg;
   rebd_pkg::sample_type smp_ff;
   rebd_pkg::result_type res_in;
   rebd_pkg::result_type res_ff;
   logic                 smp_vld_ff, smp_vld_in;
   logic                 rsp_vld_ff, rsp_vld_in;
   logic                 out_free;
   logic                 step;
   logic                 take;

   assign out_free      = !rsp_vld_ff || rsp_bus.ready;
   assign step          = smp_vld_ff && out_free;
   assign req_bus.ready = !smp_vld_ff || out_free;
   assign take          = req_bus.valid && req_bus.ready;

   assign smp_vld_in = take || (smp_vld_ff && !step);
   assign rsp_vld_in = step || (rsp_vld_ff && !rsp_bus.ready);

   assign rsp_bus.valid       = rsp_vld_ff;
   assign rsp_bus.scan_code   = res_ff.scan_code;
   assign rsp_bus.action_code = res_ff.action_code;
   assign rsp_bus.event_code  = res_ff.event_code;

   rebd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rebd_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .cfg    (cfg),
      .sample (smp_ff),
      .result (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         smp_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         smp_vld_ff <= smp_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      if (take) begin
         smp_ff.a_level   <= req_bus.a_level;
         smp_ff.b_level   <= req_bus.b_level;
         smp_ff.key_level <= req_bus.key_level;
      end
      if (step) begin
         res_ff <= res_in;
      end
   end

endmodule

>>> dv/rebd_decode_checker.sv
// Checker: watches the sample, result and register ports, predicts each result and compares
module rebd_decode_checker (
   input  logic                         clock,
   input  logic                         reset,
   rebd_req_if                          req_mon,
   rebd_rsp_if                          rsp_mon,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [rebd_pkg::PADDR_W-1:0] paddr,
   input  logic [rebd_pkg::PDATA_W-1:0] pwdata,
   input  logic                         pready,
   output int                           mismatches,
   output int                           pending
);
   import rebd_pkg::*;

   localparam int MAX_SHOWN = 100;

   typedef enum logic [1:0] {DBL_IDLE, DBL_PRESSED, DBL_RELEASED} dbl_stage_e;

   cfg_type          cfg;
   logic             a_prev;
   logic [CNT_W-1:0] press_cnt;
   logic [CNT_W-1:0] gap_cnt;
   logic [CNT_W-1:0] rep_cnt;
   logic             short_armed;
   logic             long_held;
   dbl_stage_e       dbl_stage;

   result_type       awaited_codes[$];
   result_type       want;
   int               result_beats;

   initial mismatches = 0;

   task automatic report_mismatch(input string what);
      if (mismatches < MAX_SHOWN)
         $display("%0t mismatch: %s", $time, what);
      mismatches++;
   endtask

   task automatic clear_decoder();
      cfg = '{encoder_type: 1'b1, debounce_ticks: DEBOUNCE_RST,
              long_press_ticks: LONG_PRESS_RST, double_click_ticks: DOUBLE_CLICK_RST,
              repeat_ticks: REPEAT_RST};
      a_prev      = 1'b1;
      press_cnt   = '0;
      gap_cnt     = '0;
      rep_cnt     = '0;
      short_armed = 1'b0;
      long_held   = 1'b0;
      dbl_stage   = DBL_IDLE;
   endtask

   function automatic result_type decode_sample(input sample_type s);
      int                turn;
      logic signed [2:0] scan;
      logic [2:0]        action;
      logic [2:0]        evt;
      result_type        r;
      turn   = 0;
      action = ACT_NONE;
      evt    = EVT_NONE;
      if (s.a_level != a_prev) begin
         if (!cfg.encoder_type) begin
            if (!s.a_level) turn = s.b_level ? -1 : 1;
         end else if (s.a_level) begin
            turn = s.b_level ? -1 : 1;
         end else begin
            turn = s.b_level ? 1 : -1;
         end
         a_prev = s.a_level;
      end
      if (!s.key_level)
         scan = (turn == 0) ? SCAN_KEY : (turn > 0) ? SCAN_KEY_FWD : SCAN_KEY_REV;
      else
         scan = (turn == 0) ? SCAN_NONE : (turn > 0) ? SCAN_FWD : SCAN_REV;
      case (scan)
         SCAN_FWD:     evt = EVT_INC;
         SCAN_REV:     evt = EVT_DEC;
         SCAN_KEY_FWD: evt = EVT_HELD_DEC;
         SCAN_KEY_REV: evt = EVT_HELD_INC;
         default: ;
      endcase

      // a turn with the key down counts as a release tick
      if (scan == SCAN_KEY) begin
         if (press_cnt < PRESS_COUNT_LIMIT) press_cnt = press_cnt + 1'b1;
         if (press_cnt == cfg.debounce_ticks) short_armed = 1'b1;
         if (gap_cnt != 0 && gap_cnt <= cfg.double_click_ticks) dbl_stage = DBL_PRESSED;
         if (press_cnt == cfg.long_press_ticks) begin
            long_held   = 1'b1;
            short_armed = 1'b0;
         end
      end else if (press_cnt < cfg.debounce_ticks) begin
         press_cnt   = '0;
         short_armed = 1'b0;
         long_held   = 1'b0;
         dbl_stage   = DBL_IDLE;
         gap_cnt     = '0;
      end else begin
         if (short_armed) begin
            if (dbl_stage == DBL_IDLE && gap_cnt < CNT_MAX) gap_cnt = gap_cnt + 1'b1;
            if (dbl_stage == DBL_PRESSED && gap_cnt <= cfg.double_click_ticks)
               dbl_stage = DBL_RELEASED;
            if (dbl_stage == DBL_IDLE && gap_cnt > cfg.double_click_ticks) short_armed = 1'b0;
         end
         long_held = 1'b0;
      end

      if (press_cnt > cfg.debounce_ticks) begin
         if (!short_armed && gap_cnt > cfg.double_click_ticks &&
             press_cnt < cfg.long_press_ticks) begin
            action    = ACT_SHORT;
            evt       = EVT_SHORT;
            press_cnt = '0;
            gap_cnt   = '0;
            dbl_stage = DBL_IDLE;
         end
         if (dbl_stage == DBL_RELEASED && gap_cnt != 0 &&
             gap_cnt <= cfg.double_click_ticks) begin
            action      = ACT_DOUBLE;
            evt         = EVT_DOUBLE;
            press_cnt   = '0;
            gap_cnt     = '0;
            short_armed = 1'b0;
            dbl_stage   = DBL_IDLE;
         end
         if (long_held && press_cnt >= cfg.long_press_ticks) begin
            rep_cnt = rep_cnt + 1'b1;
            if (rep_cnt >= cfg.repeat_ticks) begin
               rep_cnt = '0;
               action  = ACT_REPEAT;
            end
         end
         if (!long_held && press_cnt >= cfg.long_press_ticks) begin
            action    = ACT_LONG_END;
            press_cnt = '0;
         end
      end

      r.scan_code   = scan;
      r.action_code = action;
      r.event_code  = evt;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_decoder();
         awaited_codes.delete();
         result_beats = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[PADDR_W-1:2])
               REG_ENCODER_TYPE: cfg.encoder_type       = pwdata[0];
               REG_DEBOUNCE:     cfg.debounce_ticks     = pwdata[CNT_W-1:0];
               REG_LONG_PRESS:   cfg.long_press_ticks   = pwdata[CNT_W-1:0];
               REG_DOUBLE_CLICK: cfg.double_click_ticks = pwdata[CNT_W-1:0];
               REG_REPEAT:       cfg.repeat_ticks       = pwdata[CNT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_codes.size() == 0) begin
               report_mismatch($sformatf("result beat %0d with nothing awaited", result_beats));
            end else begin
               want = awaited_codes.pop_front();
               if (rsp_mon.scan_code !== want.scan_code)
                  report_mismatch($sformatf("beat %0d scan_code %0d, want %0d", result_beats,
                                            rsp_mon.scan_code, want.scan_code));
               if (rsp_mon.action_code !== want.action_code)
                  report_mismatch($sformatf("beat %0d action_code %0d, want %0d", result_beats,
                                            rsp_mon.action_code, want.action_code));
               if (rsp_mon.event_code !== want.event_code)
                  report_mismatch($sformatf("beat %0d event_code %0d, want %0d", result_beats,
                                            rsp_mon.event_code, want.event_code));
            end
            result_beats++;
         end
         if (req_mon.valid && req_mon.ready)
            awaited_codes.push_back(decode_sample({req_mon.a_level, req_mon.b_level,
                                                   req_mon.key_level}));
      end
      pending = awaited_codes.size();
   end

endmodule

>>> dv/tb_rotary_encoder_button_decoder.sv
// Testbench top: clock, reset, encoder and key stimulus, register phases and verdict
module tb_rotary_encoder_button_decoder;
   import rebd_pkg::*;

   localparam int PERIOD          = 10;
   localparam int RUN_LIMIT       = 5000000;
   localparam int HOLD_OFF_CYCLES = 64;
   localparam int SETTLE_CYCLES   = 8;
   localparam int PHASE_BEATS     = 150;
   localparam int PHASES          = 6;
   localparam int SPAN_CAP        = 60;

   // {a, b, key}: edge rules of the reset detent type, reversals, turns with the key down
   localparam logic [2:0] OPENING [12] = '{3'b011, 3'b111, 3'b001, 3'b101, 3'b101, 3'b010,
                                            3'b100, 3'b000, 3'b000, 3'b110, 3'b111, 3'b011};

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [PADDR_W-1:0]  paddr;
   logic [PDATA_W-1:0]  pwdata;
   logic [PDATA_W-1:0]  prdata;
   logic                pready;
   int                  mismatches;
   int                  pending;
   int                  send_idle_pct;
   int                  recv_idle_pct;
   int                  hold_off_asked = 0;
   int                  beats_sent = 0;
   logic [1:0]          quad_pos;
   cfg_type             settings;

   rebd_req_if req_bus();
   rebd_rsp_if rsp_bus();

   rotary_encoder_button_decoder DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   rebd_decode_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .pready     (pready),
      .mismatches (mismatches),
      .pending    (pending)
   );

   always #(PERIOD/2) clock = ~clock;

   initial begin
      #(RUN_LIMIT);
      $display("rotary_encoder_button_decoder verification failed");
      $finish;
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      int held;
      int hold_off_taken;
      hold_off_taken = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_taken != hold_off_asked) begin
            hold_off_taken = hold_off_asked;
            rsp_bus.ready <= 1'b0;
            for (held = 0; held < HOLD_OFF_CYCLES; held++) @(negedge clock);
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_sample(input sample_type s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid     <= 1'b0;
         req_bus.a_level   <= 1'($urandom_range(1));
         req_bus.b_level   <= 1'($urandom_range(1));
         req_bus.key_level <= 1'($urandom_range(1));
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.a_level   <= s.a_level;
      req_bus.b_level   <= s.b_level;
      req_bus.key_level <= s.key_level;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      beats_sent++;
      @(negedge clock);
   endtask

   // quadrature positions 0..3 are AB = 11, 01, 00, 10
   task automatic send_pins(input logic key);
      sample_type s;
      s.a_level   = (quad_pos == 2'd0 || quad_pos == 2'd3);
      s.b_level   = (quad_pos <= 2'd1);
      s.key_level = key;
      send_sample(s);
   endtask

   task automatic hold_pins(input int n, input logic key, input int turn_pct);
      int k;
      for (k = 0; k < n; k++) begin
         if ($urandom_range(99) < turn_pct)
            quad_pos = quad_pos + ($urandom_range(1) ? 2'd1 : 2'd3);
         send_pins(key);
      end
   endtask

   function automatic int press_span();
      int d, l, r, n;
      d = int'(settings.debounce_ticks);
      l = int'(settings.long_press_ticks);
      r = int'(settings.repeat_ticks);
      case ($urandom_range(3))
         0:       n = $urandom_range(1, d);
         1:       n = $urandom_range(d, l);
         2:       n = l + $urandom_range(0, 4 * r + 3);
         default: n = $urandom_range(1, 3);
      endcase
      if (n > SPAN_CAP) n = $urandom_range(1, SPAN_CAP);
      return n;
   endfunction

   function automatic int gap_span();
      int w, n;
      w = int'(settings.double_click_ticks);
      n = $urandom_range(1) ? $urandom_range(1, w) : w + $urandom_range(1, 4);
      if (n > SPAN_CAP) n = $urandom_range(1, SPAN_CAP);
      return n;
   endfunction

   task automatic run_gesture();
      int   pick, n, k;
      logic [1:0] dir;
      logic key;
      pick = $urandom_range(99);
      if (pick < 30) begin
         n   = $urandom_range(1, 8);
         dir = $urandom_range(1) ? 2'd1 : 2'd3;
         key = ($urandom_range(3) != 0);
         for (k = 0; k < n; k++) begin
            if ($urandom_range(4) == 0) dir = -dir;
            quad_pos = quad_pos + dir;
            send_pins(key);
         end
      end else if (pick < 88) begin
         hold_pins(press_span(), 1'b0, 6);
         hold_pins(gap_span(), 1'b1, 0);
         if ($urandom_range(2) == 0) begin
            hold_pins(press_span(), 1'b0, 6);
            hold_pins(gap_span(), 1'b1, 0);
         end
      end else begin
         n = $urandom_range(1, 6);
         for (k = 0; k < n; k++) begin
            quad_pos = 2'($urandom_range(3));
            send_pins(1'($urandom_range(1)));
         end
      end
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [PDATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic apply_settings(input cfg_type plan);
      write_reg(REG_ENCODER_TYPE, PDATA_W'(plan.encoder_type));
      write_reg(REG_DEBOUNCE,     PDATA_W'(plan.debounce_ticks));
      write_reg(REG_LONG_PRESS,   PDATA_W'(plan.long_press_ticks));
      write_reg(REG_DOUBLE_CLICK, PDATA_W'(plan.double_click_ticks));
      write_reg(REG_REPEAT,       PDATA_W'(plan.repeat_ticks));
      settings = plan;
   endtask

   function automatic cfg_type small_settings(input logic enc);
      cfg_type c;
      c.encoder_type       = enc;
      c.debounce_ticks     = CNT_W'($urandom_range(1, 6));
      c.long_press_ticks   = c.debounce_ticks + CNT_W'($urandom_range(1, 24));
      c.double_click_ticks = CNT_W'($urandom_range(1, 12));
      c.repeat_ticks       = CNT_W'($urandom_range(1, 6));
      return c;
   endfunction

   task automatic quiesce();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   initial begin
      int      p, k, mark;
      cfg_type plan;
      req_bus.valid     = 1'b0;
      req_bus.a_level   = 1'b1;
      req_bus.b_level   = 1'b1;
      req_bus.key_level = 1'b1;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      quad_pos = 2'd0;
      send_idle_pct = 15;
      recv_idle_pct = 77;
      settings = '{encoder_type: 1'b1, debounce_ticks: DEBOUNCE_RST,
                   long_press_ticks: LONG_PRESS_RST, double_click_ticks: DOUBLE_CLICK_RST,
                   repeat_ticks: REPEAT_RST};
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      for (k = 0; k < 12; k++) send_sample(sample_type'(OPENING[k]));
      quad_pos = 2'd3;

      for (p = 0; p < PHASES; p++) begin
         quiesce();
         case (p)
            0: plan = '{encoder_type: 1'b0, debounce_ticks: 14'd1, long_press_ticks: 14'd1,
                        double_click_ticks: 14'd1, repeat_ticks: 14'd1};
            3: plan = '{encoder_type: 1'b1, debounce_ticks: 14'd10000,
                        long_press_ticks: 14'd10000, double_click_ticks: 14'd10000,
                        repeat_ticks: 14'd10000};
            5: plan = '{encoder_type: 1'b1, debounce_ticks: 14'd2, long_press_ticks: 14'd10000,
                        double_click_ticks: 14'd4, repeat_ticks: 14'd3};
            default: plan = small_settings(p != 2);
         endcase
         apply_settings(plan);
         if (p < 2) begin
            send_idle_pct = 15;
            recv_idle_pct = 77;
         end else if (p < 4) begin
            send_idle_pct = 77;
            recv_idle_pct = 15;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (p == 4) hold_off_asked++;
         mark = beats_sent;
         while (beats_sent - mark < PHASE_BEATS) run_gesture();
      end

      quiesce();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0 && pending == 0)
         $display("rotary_encoder_button_decoder verification clean");
      else
         $display("rotary_encoder_button_decoder verification failed");
      $finish;
   end

endmodule
